// File: rtl/gedm_pkg.sv
`default_nettype none

package gedm_pkg;

  localparam int unsigned NumAxes    = 8;
  localparam int unsigned NumButtons = 16;
  localparam int unsigned CfgWidth   = 15;

  // Function codes of an input item
  typedef enum logic [1:0] {
    FUNC_EVENT   = 2'd0,
    FUNC_REPORT  = 2'd1,
    FUNC_CONNECT = 2'd2
  } func_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_AXIS_COUNT  = 2'd0,
    CFG_STICK_DZ    = 2'd1,
    CFG_TRIGGER_DZ  = 2'd2,
    CFG_HAT_THRESH  = 2'd3
  } cfg_reg_e;

  // Event types after the init flag is masked off
  localparam logic [6:0] KIND_BUTTON = 7'd1;
  localparam logic [6:0] KIND_AXIS   = 7'd2;

  localparam logic [3:0]  AXIS_COUNT_RST  = 4'd8;
  localparam logic [14:0] STICK_DZ_RST    = 15'd7849;
  localparam logic [7:0]  TRIGGER_DZ_RST  = 8'd30;
  localparam logic [14:0] HAT_THRESH_RST  = 15'd16384;
  localparam logic [15:0] AXIS_MIN        = 16'h8000;
  localparam logic [15:0] AXIS_MAX        = 16'h7fff;

  // Axis roles
  localparam int unsigned AX_LEFT_X   = 0;
  localparam int unsigned AX_LEFT_Y   = 1;
  localparam int unsigned AX_LEFT_TR  = 2;
  localparam int unsigned AX_RIGHT_X  = 3;
  localparam int unsigned AX_RIGHT_Y  = 4;
  localparam int unsigned AX_RIGHT_TR = 5;
  localparam int unsigned AX_HAT_X    = 6;
  localparam int unsigned AX_HAT_Y    = 7;

  // D-pad bits of the button mask
  localparam int unsigned BTN_HAT_Y_LO = 12;
  localparam int unsigned BTN_HAT_Y_HI = 13;
  localparam int unsigned BTN_HAT_X_LO = 14;
  localparam int unsigned BTN_HAT_X_HI = 15;

  typedef struct packed {
    logic [3:0]  axis_count;
    logic [14:0] stick_deadzone;
    logic [7:0]  trigger_deadzone;
    logic [14:0] hat_threshold;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         event_kind;
    logic [7:0]         event_index;
    logic signed [15:0] event_value;
  } in_item_t;

  typedef struct packed {
    logic               is_connect;
    logic [15:0]        buttons;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [7:0]         left_trig;
    logic [7:0]         right_trig;
  } out_item_t;

  typedef struct packed {
    logic                         present;
    logic [NumButtons-1:0]        button_mask;
    logic [NumAxes-1:0][15:0]     axes;
  } pad_state_t;

endpackage

`default_nettype wire

// File: rtl/gedm_in_if.sv
`default_nettype none

interface gedm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [7:0]         event_kind;
  logic [7:0]         event_index;
  logic signed [15:0] event_value;

  modport source (
    output valid, func, event_kind, event_index, event_value,
    input  ready
  );

  modport sink (
    input  valid, func, event_kind, event_index, event_value,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/gedm_out_if.sv
`default_nettype none

interface gedm_out_if;
  logic               valid;
  logic               ready;
  logic               is_connect;
  logic [15:0]        buttons;
  logic signed [15:0] left_x;
  logic signed [15:0] left_y;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic [7:0]         left_trig;
  logic [7:0]         right_trig;

  modport source (
    output valid, is_connect, buttons, left_x, left_y, right_x, right_y,
           left_trig, right_trig,
    input  ready
  );

  modport sink (
    input  valid, is_connect, buttons, left_x, left_y, right_x, right_y,
           left_trig, right_trig,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/gedm_state.sv
`default_nettype none

module gedm_state (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fire_i,
  input  wire gedm_pkg::in_item_t item_i,
  output gedm_pkg::pad_state_t    state_o
);
  import gedm_pkg::*;

  pad_state_t state_q, state_d;
  logic [6:0] kind;

  assign kind = item_i.event_kind[6:0];

  always_comb begin
    state_d = state_q;
    if (fire_i) begin
      unique case (item_i.func)
        FUNC_EVENT: begin
          // Drop events while no device is attached or the event is malformed
          if (state_q.present) begin
            if (kind == KIND_BUTTON && item_i.event_index < 8'(NumButtons)) begin
              state_d.button_mask[item_i.event_index[3:0]] = (item_i.event_value != '0);
            end else if (kind == KIND_AXIS && item_i.event_index < 8'(NumAxes)) begin
              state_d.axes[item_i.event_index[2:0]] = item_i.event_value;
            end
          end
        end
        FUNC_CONNECT: begin
          state_d.present             = 1'b1;
          state_d.button_mask         = '0;
          state_d.axes                = '0;
          state_d.axes[AX_RIGHT_Y]    = AXIS_MIN;
          state_d.axes[AX_RIGHT_TR]   = AXIS_MIN;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

// File: rtl/gedm_report.sv
`default_nettype none

module gedm_report (
  input  wire gedm_pkg::pad_state_t state_i,
  input  wire gedm_pkg::cfg_t       cfg_i,
  output gedm_pkg::out_item_t       report_o
);
  import gedm_pkg::*;

  function automatic logic [15:0] stick_dz(logic [15:0] v, logic [14:0] dz);
    logic [16:0] mag;
    mag = v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
    return (mag < {2'b00, dz}) ? 16'd0 : v;
  endfunction

  function automatic logic [15:0] neg_sat(logic [15:0] v);
    return (v == AXIS_MIN) ? AXIS_MAX : (16'd0 - v);
  endfunction

  // (v + 32768) >> 8 is the offset-binary top byte
  function automatic logic [7:0] trig_dz(logic [15:0] v, logic [7:0] dz);
    logic [7:0] t;
    t = {~v[15], v[14:8]};
    return (t < dz) ? 8'd0 : t;
  endfunction

  logic [3:0]         cnt;
  logic signed [16:0] thr_pos, thr_neg, hat_x, hat_y;
  logic [15:0]        btn;

  assign cnt     = cfg_i.axis_count;
  assign thr_pos = $signed({2'b00, cfg_i.hat_threshold});
  assign thr_neg = 17'sd0 - thr_pos;
  assign hat_x   = $signed({state_i.axes[AX_HAT_X][15], state_i.axes[AX_HAT_X]});
  assign hat_y   = $signed({state_i.axes[AX_HAT_Y][15], state_i.axes[AX_HAT_Y]});

  always_comb begin
    btn = state_i.button_mask;
    if (cnt > 4'(AX_HAT_X)) begin
      if (hat_x < thr_neg) btn[BTN_HAT_X_LO] = 1'b1;
      if (hat_x > thr_pos) btn[BTN_HAT_X_HI] = 1'b1;
    end
    if (cnt > 4'(AX_HAT_Y)) begin
      if (hat_y < thr_neg) btn[BTN_HAT_Y_LO] = 1'b1;
      if (hat_y > thr_pos) btn[BTN_HAT_Y_HI] = 1'b1;
    end
  end

  always_comb begin
    report_o            = '0;
    report_o.is_connect = 1'b0;
    report_o.buttons    = btn;
    if (cnt > 4'(AX_LEFT_X)) begin
      report_o.left_x = stick_dz(state_i.axes[AX_LEFT_X], cfg_i.stick_deadzone);
    end
    if (cnt > 4'(AX_LEFT_Y)) begin
      report_o.left_y = neg_sat(stick_dz(state_i.axes[AX_LEFT_Y], cfg_i.stick_deadzone));
    end
    if (cnt > 4'(AX_LEFT_TR)) begin
      report_o.left_trig = trig_dz(state_i.axes[AX_LEFT_TR], cfg_i.trigger_deadzone);
    end
    if (cnt > 4'(AX_RIGHT_X)) begin
      report_o.right_x = stick_dz(state_i.axes[AX_RIGHT_X], cfg_i.stick_deadzone);
    end
    if (cnt > 4'(AX_RIGHT_Y)) begin
      report_o.right_y = neg_sat(stick_dz(state_i.axes[AX_RIGHT_Y], cfg_i.stick_deadzone));
    end
    if (cnt > 4'(AX_RIGHT_TR)) begin
      report_o.right_trig = trig_dz(state_i.axes[AX_RIGHT_TR], cfg_i.trigger_deadzone);
    end
  end

endmodule

`default_nettype wire

// File: rtl/gamepad_event_deadzone_mapper.sv
// Gamepad event mapper: keeps a 16-bit button mask and eight axis positions from
// joystick driver events and, on a report request with a device attached, emits
// one state report with stick deadzones, 8-bit triggers and hat d-pad bits,
// gated by the axis count. A connect request resets the state and emits a zeroed
// connect report. An item is taken into an input register, then applied to the
// state and turned into a result, and the result waits in an output register;
// the block accepts one item per cycle while the input register can advance, a
// stall on the output side holding back the input only once the input register
// is full. Configuration writes are taken at any cycle but must only be issued
// while the block is idle.
`default_nettype none

module gamepad_event_deadzone_mapper (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  gedm_in_if.sink                           in_i,
  gedm_out_if.source                        out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_idx_i,
  input  wire logic [gedm_pkg::CfgWidth-1:0] cfg_wdata_i
);
  import gedm_pkg::*;

  cfg_t       cfg_q;
  in_item_t   in_q;
  logic       in_vld_q;
  out_item_t  out_q;
  logic       out_vld_q;
  pad_state_t pad_state;
  out_item_t  report;
  out_item_t  result;
  in_item_t   in_item;
  logic       has_result, out_free, advance, in_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis_count       <= AXIS_COUNT_RST;
      cfg_q.stick_deadzone   <= STICK_DZ_RST;
      cfg_q.trigger_deadzone <= TRIGGER_DZ_RST;
      cfg_q.hat_threshold    <= HAT_THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_AXIS_COUNT: cfg_q.axis_count       <= cfg_wdata_i[3:0];
        CFG_STICK_DZ:   cfg_q.stick_deadzone   <= cfg_wdata_i[14:0];
        CFG_TRIGGER_DZ: cfg_q.trigger_deadzone <= cfg_wdata_i[7:0];
        CFG_HAT_THRESH: cfg_q.hat_threshold    <= cfg_wdata_i[14:0];
        default: begin
        end
      endcase
    end
  end

  assign in_item.func        = in_i.func;
  assign in_item.event_kind  = in_i.event_kind;
  assign in_item.event_index = in_i.event_index;
  assign in_item.event_value = in_i.event_value;

  // Only connect and a report with a device attached produce a transaction
  assign has_result = (in_q.func == FUNC_CONNECT) ||
                      ((in_q.func == FUNC_REPORT) && pad_state.present);
  assign out_free   = !out_vld_q || out_o.ready;
  assign advance    = in_vld_q && (!has_result || out_free);
  assign in_ready   = !in_vld_q || advance;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_q <= in_item;
    end
  end

  gedm_state u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .item_i  (in_q),
    .state_o (pad_state)
  );

  gedm_report u_report (
    .state_i  (pad_state),
    .cfg_i    (cfg_q),
    .report_o (report)
  );

  always_comb begin
    if (in_q.func == FUNC_CONNECT) begin
      result            = '0;
      result.is_connect = 1'b1;
    end else begin
      result = report;
    end
  end

  // Output register: load on a new result, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && has_result) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      out_q <= result;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.is_connect = out_q.is_connect;
  assign out_o.buttons    = out_q.buttons;
  assign out_o.left_x     = out_q.left_x;
  assign out_o.left_y     = out_q.left_y;
  assign out_o.right_x    = out_q.right_x;
  assign out_o.right_y    = out_q.right_y;
  assign out_o.left_trig  = out_q.left_trig;
  assign out_o.right_trig = out_q.right_trig;

endmodule

`default_nettype wire
